/* rtl/rkt_pkg.sv */
package rkt_pkg;

  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned KEY_BITS = 64;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);

  localparam int unsigned OP_W   = 3;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned ST_W   = 3;

  localparam logic [OP_W-1:0] OP_INSERT_KEEP   = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT_UPDATE = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP        = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE        = 3'd3;
  localparam logic [OP_W-1:0] OP_SUCCESSOR     = 3'd4;

  localparam logic [ST_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_SUCC   = 3'd4;

  typedef logic [KEY_BITS-1:0] ring_key_t;
  typedef logic [ADDR_W-1:0]   net_addr_t;
  typedef logic [IDX_W-1:0]    slot_idx_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [KEY_W-1:0]  key_out;
    logic [ADDR_W-1:0] address_out;
  } out_item_t;

endpackage

/* rtl/ring_key_table_with_successor.sv */
// Ring key table with closest-successor search. Holds up to rkt_pkg::ENTRIES unique keys
// (rkt_pkg::KEY_BITS bits, upper input key bits ignored), each with a 48-bit address.
// Opcodes: insert-keep, insert-or-update, lookup, remove, closest successor; every
// accepted item returns exactly one result. Each item scans the whole table once, one
// entry per cycle through a single-port key/address memory and one shared subtractor
// that serves both the equality match (difference zero) and the ring distance compare.
// After input transfer an item passes through the scan (S_SCAN), the table update
// (S_FIN), S_OUT holding the result until it is taken, and S_IDLE before the next
// input transfer; in_ready_o is low from input transfer through the result transfer.
// The valid map is cleared by reset; no clearing pass is needed.
module ring_key_table_with_successor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rkt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rkt_pkg::out_item_t out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [rkt_pkg::CNT_W-1:0] CNT_END = rkt_pkg::CNT_W'(rkt_pkg::ENTRIES);

  logic [1:0] state_q, state_d;
  logic [rkt_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic pend_q, pend_d;
  rkt_pkg::slot_idx_t pidx_q, pidx_d;
  logic [rkt_pkg::ENTRIES-1:0] valid_q, valid_d;

  logic [rkt_pkg::OP_W-1:0] op_q, op_d;
  rkt_pkg::ring_key_t key_q, key_d;
  rkt_pkg::net_addr_t addr_q, addr_d;

  logic hit_q, hit_d;
  rkt_pkg::slot_idx_t slot_q, slot_d;
  rkt_pkg::net_addr_t haddr_q, haddr_d;
  logic free_q, free_d;
  rkt_pkg::slot_idx_t fslot_q, fslot_d;
  logic have_q, have_d;
  rkt_pkg::ring_key_t best_q, best_d;
  rkt_pkg::ring_key_t bkey_q, bkey_d;
  rkt_pkg::net_addr_t baddr_q, baddr_d;

  rkt_pkg::out_item_t out_q, out_d;

  rkt_pkg::ring_key_t mem_key [rkt_pkg::ENTRIES];
  rkt_pkg::net_addr_t mem_addr [rkt_pkg::ENTRIES];
  rkt_pkg::ring_key_t rd_key_q;
  rkt_pkg::net_addr_t rd_addr_q;
  rkt_pkg::slot_idx_t rd_idx;
  logic we;
  rkt_pkg::slot_idx_t wr_idx;
  rkt_pkg::ring_key_t wr_key;
  rkt_pkg::net_addr_t wr_addr;

  rkt_pkg::ring_key_t ring_diff;
  logic ent_v;
  logic is_insert;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

  // shared subtractor: zero means key match, otherwise ring distance
  assign ring_diff = rd_key_q - key_q;
  assign ent_v = valid_q[pidx_q];
  assign is_insert = (op_q == rkt_pkg::OP_INSERT_KEEP) || (op_q == rkt_pkg::OP_INSERT_UPDATE);
  assign rd_idx = cnt_q[rkt_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_key[wr_idx]  <= wr_key;
      mem_addr[wr_idx] <= wr_addr;
    end
    rd_key_q  <= mem_key[rd_idx];
    rd_addr_q <= mem_addr[rd_idx];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pend_d  = 1'b0;
    pidx_d  = pidx_q;
    valid_d = valid_q;
    op_d    = op_q;
    key_d   = key_q;
    addr_d  = addr_q;
    hit_d   = hit_q;
    slot_d  = slot_q;
    haddr_d = haddr_q;
    free_d  = free_q;
    fslot_d = fslot_q;
    have_d  = have_q;
    best_d  = best_q;
    bkey_d  = bkey_q;
    baddr_d = baddr_q;
    out_d   = out_q;
    we      = 1'b0;
    wr_idx  = slot_q;
    wr_key  = key_q;
    wr_addr = addr_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.opcode;
          key_d   = in_data_i.key[rkt_pkg::KEY_BITS-1:0];
          addr_d  = in_data_i.address;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          have_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q != CNT_END) begin
          pend_d = 1'b1;
          pidx_d = rd_idx;
          cnt_d  = cnt_q + 1'b1;
        end
        if (pend_q) begin
          if (ent_v && (ring_diff == '0) && !hit_q) begin
            hit_d   = 1'b1;
            slot_d  = pidx_q;
            haddr_d = rd_addr_q;
          end
          if (!ent_v && !free_q) begin
            free_d  = 1'b1;
            fslot_d = pidx_q;
          end
          if (ent_v && (ring_diff != '0) && (!have_q || (ring_diff < best_q))) begin
            have_d  = 1'b1;
            best_d  = ring_diff;
            bkey_d  = rd_key_q;
            baddr_d = rd_addr_q;
          end
          if (cnt_q == CNT_END) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        out_d.status      = rkt_pkg::ST_NOT_FOUND;
        out_d.key_out     = '0;
        out_d.address_out = '0;
        case (op_q)
          rkt_pkg::OP_INSERT_KEEP, rkt_pkg::OP_INSERT_UPDATE: begin
            if (hit_q) begin
              out_d.status  = rkt_pkg::ST_FOUND;
              out_d.key_out = rkt_pkg::KEY_W'(key_q);
              if (op_q == rkt_pkg::OP_INSERT_UPDATE) begin
                we                = 1'b1;
                out_d.address_out = addr_q;
              end else begin
                out_d.address_out = haddr_q;
              end
            end else if (free_q) begin
              we                = 1'b1;
              wr_idx            = fslot_q;
              valid_d[fslot_q]  = 1'b1;
              out_d.status      = rkt_pkg::ST_INSERTED;
              out_d.key_out     = rkt_pkg::KEY_W'(key_q);
              out_d.address_out = addr_q;
            end else begin
              out_d.status = rkt_pkg::ST_FULL;
            end
          end
          rkt_pkg::OP_LOOKUP, rkt_pkg::OP_REMOVE: begin
            if (hit_q) begin
              out_d.status      = rkt_pkg::ST_FOUND;
              out_d.key_out     = rkt_pkg::KEY_W'(key_q);
              out_d.address_out = haddr_q;
              if (op_q == rkt_pkg::OP_REMOVE) begin
                valid_d[slot_q] = 1'b0;
              end
            end
          end
          rkt_pkg::OP_SUCCESSOR: begin
            if (have_q) begin
              out_d.status      = rkt_pkg::ST_FOUND;
              out_d.key_out     = rkt_pkg::KEY_W'(bkey_q);
              out_d.address_out = baddr_q;
            end else begin
              out_d.status = rkt_pkg::ST_NO_SUCC;
            end
          end
          default: begin
            out_d.status = rkt_pkg::ST_NOT_FOUND;
          end
        endcase
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    op_q    <= op_d;
    key_q   <= key_d;
    addr_q  <= addr_d;
    slot_q  <= slot_d;
    haddr_q <= haddr_d;
    fslot_q <= fslot_d;
    best_q  <= best_d;
    bkey_q  <= bkey_d;
    baddr_q <= baddr_d;
    out_q   <= out_d;
  end

`ifndef SYNTHESIS
  a_scan_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ##(rkt_pkg::ENTRIES + 1) (state_q == S_FIN))
    else $error("scan did not end after one pass over the table");

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != rkt_pkg::ST_FOUND)
     && (out_data_o.status != rkt_pkg::ST_INSERTED))
    |-> ((out_data_o.key_out == '0) && (out_data_o.address_out == '0)))
    else $error("miss result carries nonzero key or address");

  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && is_insert && !hit_q && free_q) |=> valid_q[$past(fslot_q)])
    else $error("inserted entry not marked valid");

  a_remove_clears_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && (op_q == rkt_pkg::OP_REMOVE) && hit_q) |=> !valid_q[$past(slot_q)])
    else $error("removed entry still valid");

  a_valid_only_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FIN) |=> $stable(valid_q))
    else $error("valid map changed outside the update cycle");
`endif

endmodule

/* verif/tb_ring_key_table_with_successor.sv */
module tb_ring_key_table_with_successor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rkt_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [rkt_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [rkt_pkg::KEY_W-1:0] KEY_TOP  = '1;
  localparam logic [rkt_pkg::KEY_W-1:0] KEY_HALF = {1'b1, {(rkt_pkg::KEY_W-1){1'b0}}};
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned RECENT_DEPTH = 128;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef enum {MODE_FILL, MODE_MIXED, MODE_SEARCH, MODE_PURGE} phase_e;

  typedef struct {
    rkt_pkg::in_item_t item;
    bit                drain_first;
  } send_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  rkt_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  rkt_pkg::out_item_t out_data_o;

  send_t              pending[$];
  rkt_pkg::out_item_t answer_q[$];

  bit                 slot_used[rkt_pkg::ENTRIES];
  rkt_pkg::ring_key_t slot_key[rkt_pkg::ENTRIES];
  rkt_pkg::net_addr_t slot_addr[rkt_pkg::ENTRIES];

  logic [rkt_pkg::KEY_W-1:0] recent[RECENT_DEPTH];
  int unsigned recent_wr = 0;

  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          held_once = 1'b0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned status_seen[2**rkt_pkg::ST_W];

  ring_key_table_with_successor DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int find_key(rkt_pkg::ring_key_t k);
    for (int i = 0; i < rkt_pkg::ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // updates the table copy and returns the answer for one transfer
  function automatic rkt_pkg::out_item_t ring_table_answer(rkt_pkg::in_item_t it);
    rkt_pkg::ring_key_t k;
    rkt_pkg::net_addr_t a;
    rkt_pkg::out_item_t r;
    rkt_pkg::ring_key_t ring_diff;
    rkt_pkg::ring_key_t best;
    bit                 have;
    int                 slot;
    k = it.key[rkt_pkg::KEY_BITS-1:0];
    a = it.address;
    r = '0;
    r.status = rkt_pkg::ST_NOT_FOUND;
    best = '0;
    have = 1'b0;
    slot = -1;
    case (it.opcode)
      rkt_pkg::OP_INSERT_KEEP, rkt_pkg::OP_INSERT_UPDATE: begin
        slot = find_key(k);
        if (slot >= 0) begin
          if (it.opcode == rkt_pkg::OP_INSERT_UPDATE) slot_addr[slot] = a;
          r.status = rkt_pkg::ST_FOUND;
          r.key_out[rkt_pkg::KEY_BITS-1:0] = k;
          r.address_out = slot_addr[slot];
        end else begin
          for (int i = rkt_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!slot_used[i]) slot = i;
          end
          if (slot < 0) begin
            r.status = rkt_pkg::ST_FULL;
          end else begin
            slot_used[slot] = 1'b1;
            slot_key[slot] = k;
            slot_addr[slot] = a;
            r.status = rkt_pkg::ST_INSERTED;
            r.key_out[rkt_pkg::KEY_BITS-1:0] = k;
            r.address_out = a;
          end
        end
      end
      rkt_pkg::OP_LOOKUP, rkt_pkg::OP_REMOVE: begin
        slot = find_key(k);
        if (slot >= 0) begin
          r.status = rkt_pkg::ST_FOUND;
          r.key_out[rkt_pkg::KEY_BITS-1:0] = k;
          r.address_out = slot_addr[slot];
          if (it.opcode == rkt_pkg::OP_REMOVE) slot_used[slot] = 1'b0;
        end
      end
      rkt_pkg::OP_SUCCESSOR: begin
        for (int i = 0; i < rkt_pkg::ENTRIES; i++) begin
          if (slot_used[i]) begin
            ring_diff = slot_key[i] - k;
            if (ring_diff != '0 && (!have || ring_diff < best)) begin
              have = 1'b1;
              best = ring_diff;
              slot = i;
            end
          end
        end
        if (have) begin
          r.status = rkt_pkg::ST_FOUND;
          r.key_out[rkt_pkg::KEY_BITS-1:0] = slot_key[slot];
          r.address_out = slot_addr[slot];
        end else begin
          r.status = rkt_pkg::ST_NO_SUCC;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic queue_item(logic [rkt_pkg::OP_W-1:0] op, logic [rkt_pkg::KEY_W-1:0] k,
                            logic [rkt_pkg::ADDR_W-1:0] a, bit drain_first = 1'b0);
    send_t s;
    s.item.opcode = op;
    s.item.key = k;
    s.item.address = a;
    s.drain_first = drain_first;
    pending.push_back(s);
  endtask

  function automatic logic [rkt_pkg::KEY_W-1:0] pick_key(int unsigned fresh_pct);
    logic [rkt_pkg::KEY_W-1:0] k;
    if ($urandom_range(99) < fresh_pct) begin
      case ($urandom_range(9))
        0: k = '0;
        1: k = KEY_TOP;
        2: k = recent[$urandom_range(RECENT_DEPTH - 1)] + 1'b1;
        3: k = recent[$urandom_range(RECENT_DEPTH - 1)] - 1'b1;
        default: k = {$urandom, $urandom};
      endcase
      recent[recent_wr] = k;
      recent_wr = (recent_wr + 1) % RECENT_DEPTH;
    end else begin
      k = recent[$urandom_range(RECENT_DEPTH - 1)];
    end
    return k;
  endfunction

  function automatic logic [rkt_pkg::OP_W-1:0] pick_op(phase_e ph);
    int unsigned r;
    int unsigned w_ins;
    int unsigned w_look;
    int unsigned w_rem;
    case (ph)
      MODE_FILL:   begin w_ins = 80; w_look = 6;  w_rem = 5;  end
      MODE_MIXED:  begin w_ins = 30; w_look = 20; w_rem = 20; end
      MODE_SEARCH: begin w_ins = 10; w_look = 35; w_rem = 5;  end
      default:     begin w_ins = 5;  w_look = 10; w_rem = 72; end
    endcase
    r = $urandom_range(99);
    if (r < 3) return rkt_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    r = r - 3;
    if (r < w_ins) return r[0] ? rkt_pkg::OP_INSERT_UPDATE : rkt_pkg::OP_INSERT_KEEP;
    if (r < w_ins + w_look) return rkt_pkg::OP_LOOKUP;
    if (r < w_ins + w_look + w_rem) return rkt_pkg::OP_REMOVE;
    return rkt_pkg::OP_SUCCESSOR;
  endfunction

  // wait before the next transfer, with occasional stretches of back-to-back traffic
  function automatic int unsigned draw_gap(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(29) == 0) calm_left = $urandom_range(15, 40);
    return $urandom_range(9);
  endfunction

  task automatic report_mismatch(string what, logic [rkt_pkg::KEY_W-1:0] got,
                                 logic [rkt_pkg::KEY_W-1:0] want);
    $display("mismatch @%0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(negedge clk_i) begin : drive_in
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_taken) send_gap = draw_gap(send_calm);
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending.size() != 0 && !(pending[0].drain_first && answer_q.size() != 0)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending[0].item;
        pending.delete(0);
        items_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drive_out
    if (rst_ni) begin
      if (out_taken) begin
        recv_wait = draw_gap(recv_calm);
        if (!held_once && results_seen >= HOLD_AT) begin
          held_once = 1'b1;
          recv_wait = LONG_HOLD;
        end
      end
      if (recv_wait != 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    rkt_pkg::out_item_t want;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected result, status", rkt_pkg::KEY_W'(out_data_o.status), '0);
      end else begin
        want = answer_q.pop_front();
        status_seen[want.status]++;
        if (out_data_o.status !== want.status)
          report_mismatch("status", rkt_pkg::KEY_W'(out_data_o.status),
                          rkt_pkg::KEY_W'(want.status));
        if (out_data_o.key_out !== want.key_out)
          report_mismatch("key_out", out_data_o.key_out, want.key_out);
        if (out_data_o.address_out !== want.address_out)
          report_mismatch("address_out", rkt_pkg::KEY_W'(out_data_o.address_out),
                          rkt_pkg::KEY_W'(want.address_out));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) answer_q.push_back(ring_table_answer(in_data_i));
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("tb_ring_key_table_with_successor: done, errors");
    $finish;
  end

  initial begin : stimulus
    phase_e      ph;
    int unsigned n;
    int unsigned len;
    int unsigned fresh;
    for (int i = 0; i < RECENT_DEPTH; i++) recent[i] = {$urandom, $urandom};

    // directed: empty table, keep vs update, ring wrap, spare opcodes, removal
    queue_item(rkt_pkg::OP_LOOKUP, '0, '1);
    queue_item(rkt_pkg::OP_SUCCESSOR, '0, '0);
    queue_item(rkt_pkg::OP_REMOVE, KEY_TOP, '0);
    queue_item(rkt_pkg::OP_INSERT_KEEP, '0, '1);
    queue_item(rkt_pkg::OP_SUCCESSOR, '0, '0);
    queue_item(rkt_pkg::OP_INSERT_KEEP, '0, '0);
    queue_item(rkt_pkg::OP_INSERT_UPDATE, '0, 48'h1234_5678_9abc);
    queue_item(rkt_pkg::OP_INSERT_UPDATE, KEY_TOP, '0);
    queue_item(rkt_pkg::OP_SUCCESSOR, '0, '1);
    queue_item(rkt_pkg::OP_SUCCESSOR, KEY_TOP, '0);
    queue_item(rkt_pkg::OP_SUCCESSOR, 64'd5, '0);
    queue_item(rkt_pkg::OP_LOOKUP, KEY_TOP, '0);
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
      queue_item(rkt_pkg::OP_W'(c), '0, '1);
    queue_item(rkt_pkg::OP_LOOKUP, '0, '0);
    queue_item(rkt_pkg::OP_INSERT_KEEP, KEY_HALF, 48'haaaa_aaaa_aaaa);
    queue_item(rkt_pkg::OP_SUCCESSOR, KEY_HALF - 1'b1, '0);
    queue_item(rkt_pkg::OP_REMOVE, '0, '0);
    queue_item(rkt_pkg::OP_REMOVE, '0, '0);
    queue_item(rkt_pkg::OP_LOOKUP, '0, '0);
    queue_item(rkt_pkg::OP_REMOVE, KEY_TOP, 48'h5555_5555_5555);
    queue_item(rkt_pkg::OP_REMOVE, KEY_HALF, '0);
    queue_item(rkt_pkg::OP_SUCCESSOR, KEY_HALF, '0);

    // random phases; each starts only once the table has answered everything
    ph = MODE_FILL;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      case (ph)
        MODE_FILL:   begin len = 120; fresh = 70; end
        MODE_MIXED:  begin len = 60;  fresh = 30; end
        MODE_SEARCH: begin len = 60;  fresh = 20; end
        default:     begin len = 100; fresh = 10; end
      endcase
      for (int j = 0; j < len && n < RANDOM_ITEMS; j++) begin
        queue_item(pick_op(ph), pick_key(fresh), rkt_pkg::ADDR_W'({$urandom, $urandom}),
                   j == 0);
        n++;
      end
      ph = ph.next();
    end

    repeat (8) @(posedge clk_i);
    #3 rst_ni = 1'b1;

    while (pending.size() != 0 || in_valid_i || answer_q.size() != 0) @(posedge clk_i);
    repeat (rkt_pkg::ENTRIES + 8) @(posedge clk_i);

    $display("covered %0d transfers in, %0d out: found %0d, inserted %0d, missing %0d,",
             items_sent, results_seen, status_seen[rkt_pkg::ST_FOUND],
             status_seen[rkt_pkg::ST_INSERTED], status_seen[rkt_pkg::ST_NOT_FOUND]);
    $display("  table full %0d, no successor %0d, one long output stall",
             status_seen[rkt_pkg::ST_FULL], status_seen[rkt_pkg::ST_NO_SUCC]);
    if (errors == 0) begin
      $display("tb_ring_key_table_with_successor: done, clean");
    end else begin
      $display("tb_ring_key_table_with_successor: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rkt_pkg.sv
rtl/ring_key_table_with_successor.sv
verif/tb_ring_key_table_with_successor.sv
